/* rtl/zso_pkg.sv */
// ============================================================================
// zso_pkg - zebra stripe overlay shared definitions
// Register map codes, sequencer states and the result word layout.
// ============================================================================
package zso_pkg;

   // Fixed field widths
   localparam int CHAN_W   = 8;
   localparam int LUMA_W   = 9;
   localparam int SIZE_W   = 13;
   localparam int COLOR_W  = 32;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REGIDX_W = 3;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [REGIDX_W-1:0] {
      REG_LUMA   = 3'd0,
      REG_STRIPE = 3'd1,
      REG_WIDTH  = 3'd2,
      REG_HEIGHT = 3'd3,
      REG_FORE   = 3'd4,
      REG_BACK   = 3'd5
   } reg_index_type;

   // Reset values of the registers
   localparam logic [LUMA_W-1:0]  LUMA_RST   = 9'd240;
   localparam logic [SIZE_W-1:0]  STRIPE_RST = 13'd8;
   localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd1920;
   localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd1080;
   localparam logic [COLOR_W-1:0] FORE_RST   = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] BACK_RST   = 32'hFF00_0000;

   // Phase recompute sequencer
   typedef enum logic [1:0] {
      ST_RUN  = 2'd0,
      ST_LOAD = 2'd1,
      ST_CALC = 2'd2
   } seq_state_type;

   // One overlay pixel
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              frame_end;
   } result_type;

   // Divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic quot_lsb;
   } div_status_type;

endpackage

/* rtl/zebra_stripe_overlay_unit.sv */
// ============================================================================
// zebra_stripe_overlay_unit - zebra stripe exposure overlay
// Paints diagonal stripes over pixels whose brightest channel reaches the
// threshold and emits one RGBA overlay word per input pixel.
// ============================================================================
// Usage:
//   req_* carries RGB pixels in raster order; a word moves when valid is high
//   and stall is low. rsp_* returns one RGBA overlay word per pixel, with
//   frame_end flagging the last pixel of each frame.
//   The overlay word of an accepted pixel is registered; one pixel per
//   cycle is sustained unless a stall holds it. The overlay logic sits
//   between the column/row phase registers and the output register.
//   A two-entry output buffer (output register plus skid) lets the input
//   keep accepting while a result waits; req_stall rises only when both
//   entries are full, while a register write is on the port (setup and
//   access cycles) or while the stripe phases are reloaded.
//   Writing stripe_size reloads the stripe phases from the counters through
//   a bit-serial divider; no pixel is accepted until the reload is done.
//   Other register writes take effect on the next pixel.
//   Reset (synchronous) loads register defaults, clears the position
//   counters and phases and empties the output buffer.
// ============================================================================
module zebra_stripe_overlay_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [zso_pkg::CHAN_W-1:0]      req_red_in,
   input  logic [zso_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [zso_pkg::CHAN_W-1:0]      req_blue_in,
   // overlay output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [zso_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic [zso_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [zso_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic [zso_pkg::CHAN_W-1:0]      rsp_alpha_out,
   output logic                            rsp_frame_end,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [zso_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [zso_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [zso_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int XW = ((CW > zso_pkg::SIZE_W) ? CW : zso_pkg::SIZE_W) + 1;

   // Registers
   logic [zso_pkg::LUMA_W-1:0]  luma_ff;
   logic [zso_pkg::SIZE_W-1:0]  stripe_ff;
   logic [zso_pkg::SIZE_W-1:0]  width_ff;
   logic [zso_pkg::SIZE_W-1:0]  height_ff;
   logic [zso_pkg::COLOR_W-1:0] fore_ff;
   logic [zso_pkg::COLOR_W-1:0] back_ff;

   // Position and phase state
   logic [CW-1:0] col_ff,    col_in;
   logic [CW-1:0] row_ff,    row_in;
   logic [CW-1:0] pphase_ff, pphase_in;
   logic          ppar_ff,   ppar_in;
   logic [CW-1:0] lphase_ff, lphase_in;
   logic          lpar_ff,   lpar_in;

   // Sequencer
   zso_pkg::seq_state_type state_ff, state_in;
   logic div_start;
   logic phase_load;

   // Output buffer
   zso_pkg::result_type out_ff, out_in, skid_ff, skid_in, res_new;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;

   // Misc
   logic [zso_pkg::REGIDX_W-1:0] csr_idx;
   logic                         csr_wr;
   logic                         stripe_wr;
   logic                         accept;
   logic                         out_take;
   logic [XW-1:0]                s_eff;
   logic [XW-1:0]                w_eff;
   logic [XW-1:0]                h_eff;
   logic [zso_pkg::CHAN_W-1:0]   max_rg;
   logic [zso_pkg::CHAN_W-1:0]   max_rgb;
   logic [CW:0]                  phase_sum;
   logic                         parity;
   logic                         hit;
   logic [zso_pkg::COLOR_W-1:0]  color;
   logic                         line_end;
   logic                         frame_end;
   logic                         pwrap;
   logic                         lwrap;
   logic [CW-1:0]                col_rem;
   logic [CW-1:0]                row_rem;
   zso_pkg::div_status_type      col_st;
   zso_pkg::div_status_type      row_st;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   assign csr_idx    = csr_paddr[zso_pkg::ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign stripe_wr  = csr_wr && (csr_idx == zso_pkg::REG_STRIPE);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_ff   <= zso_pkg::LUMA_RST;
         stripe_ff <= zso_pkg::STRIPE_RST;
         width_ff  <= zso_pkg::WIDTH_RST;
         height_ff <= zso_pkg::HEIGHT_RST;
         fore_ff   <= zso_pkg::FORE_RST;
         back_ff   <= zso_pkg::BACK_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            zso_pkg::REG_LUMA:   luma_ff   <= csr_pwdata[zso_pkg::LUMA_W-1:0];
            zso_pkg::REG_STRIPE: stripe_ff <= csr_pwdata[zso_pkg::SIZE_W-1:0];
            zso_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[zso_pkg::SIZE_W-1:0];
            zso_pkg::REG_HEIGHT: height_ff <= csr_pwdata[zso_pkg::SIZE_W-1:0];
            zso_pkg::REG_FORE:   fore_ff   <= csr_pwdata;
            zso_pkg::REG_BACK:   back_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (csr_idx)
         zso_pkg::REG_LUMA:   csr_prdata = zso_pkg::DATA_W'(luma_ff);
         zso_pkg::REG_STRIPE: csr_prdata = zso_pkg::DATA_W'(stripe_ff);
         zso_pkg::REG_WIDTH:  csr_prdata = zso_pkg::DATA_W'(width_ff);
         zso_pkg::REG_HEIGHT: csr_prdata = zso_pkg::DATA_W'(height_ff);
         zso_pkg::REG_FORE:   csr_prdata = fore_ff;
         zso_pkg::REG_BACK:   csr_prdata = back_ff;
         default:             csr_prdata = '0;
      endcase
   end

   // Effective sizes: zero reads as one, dimensions capped at MAX_DIM
   assign s_eff = (stripe_ff == '0) ? XW'(1) : XW'(stripe_ff);

   always_comb begin
      if (width_ff == '0)
         w_eff = XW'(1);
      else if (XW'(width_ff) > XW'(MAX_DIM))
         w_eff = XW'(MAX_DIM);
      else
         w_eff = XW'(width_ff);
      if (height_ff == '0)
         h_eff = XW'(1);
      else if (XW'(height_ff) > XW'(MAX_DIM))
         h_eff = XW'(MAX_DIM);
      else
         h_eff = XW'(height_ff);
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign req_stall = skid_valid_ff || (state_ff != zso_pkg::ST_RUN) ||
                      (csr_psel && csr_pwrite);
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   // ---------------------------------------------------------------------
   // Overlay datapath
   // ---------------------------------------------------------------------
   assign max_rg    = (req_green_in > req_red_in) ? req_green_in : req_red_in;
   assign max_rgb   = (req_blue_in > max_rg) ? req_blue_in : max_rg;
   assign hit       = zso_pkg::LUMA_W'(max_rgb) >= luma_ff;
   assign phase_sum = {1'b0, pphase_ff} + {1'b0, lphase_ff};
   assign parity    = ppar_ff ^ lpar_ff ^ (XW'(phase_sum) >= s_eff);
   assign color     = hit ? (parity ? fore_ff : back_ff) : '0;

   assign line_end  = (XW'(col_ff) + XW'(1)) >= w_eff;
   assign frame_end = line_end && ((XW'(row_ff) + XW'(1)) >= h_eff);

   assign res_new.red       = color[7:0];
   assign res_new.green     = color[15:8];
   assign res_new.blue      = color[23:16];
   assign res_new.alpha     = color[31:24];
   assign res_new.frame_end = frame_end;

   // Phase steps: carry into parity when a phase reaches the stripe size
   assign pwrap = (XW'(pphase_ff) + XW'(1)) == s_eff;
   assign lwrap = (XW'(lphase_ff) + XW'(1)) == s_eff;

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      pphase_in = pphase_ff;
      ppar_in   = ppar_ff;
      lphase_in = lphase_ff;
      lpar_in   = lpar_ff;
      if (phase_load) begin
         pphase_in = col_rem;
         ppar_in   = col_st.quot_lsb;
         lphase_in = row_rem;
         lpar_in   = row_st.quot_lsb;
      end else if (accept) begin
         if (line_end) begin
            col_in    = '0;
            pphase_in = '0;
            ppar_in   = 1'b0;
            if (frame_end) begin
               row_in    = '0;
               lphase_in = '0;
               lpar_in   = 1'b0;
            end else begin
               row_in    = row_ff + CW'(1);
               lphase_in = lwrap ? '0 : lphase_ff + CW'(1);
               lpar_in   = lpar_ff ^ lwrap;
            end
         end else begin
            col_in    = col_ff + CW'(1);
            pphase_in = pwrap ? '0 : pphase_ff + CW'(1);
            ppar_in   = ppar_ff ^ pwrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         pphase_ff <= '0;
         ppar_ff   <= 1'b0;
         lphase_ff <= '0;
         lpar_ff   <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         pphase_ff <= pphase_in;
         ppar_ff   <= ppar_in;
         lphase_ff <= lphase_in;
         lpar_ff   <= lpar_in;
      end
   end

   // ---------------------------------------------------------------------
   // Phase reload after a stripe size write
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         zso_pkg::ST_RUN: begin
            if (stripe_wr) state_in = zso_pkg::ST_LOAD;
         end
         zso_pkg::ST_LOAD: begin
            if (!stripe_wr) state_in = zso_pkg::ST_CALC;
         end
         zso_pkg::ST_CALC: begin
            if (stripe_wr)
               state_in = zso_pkg::ST_LOAD;
            else if (col_st.done)
               state_in = zso_pkg::ST_RUN;
         end
         default: state_in = zso_pkg::ST_RUN;
      endcase
   end

   always_comb begin
      div_start  = (state_ff == zso_pkg::ST_LOAD) && !stripe_wr;
      phase_load = (state_ff == zso_pkg::ST_CALC) && col_st.done && !stripe_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= zso_pkg::ST_RUN;
      else       state_ff <= state_in;
   end

   zso_div #(.CW(CW)) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (col_ff),
      .divisor   (s_eff[zso_pkg::SIZE_W-1:0]),
      .remainder (col_rem),
      .status    (col_st)
   );

   zso_div #(.CW(CW)) u_row_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (row_ff),
      .divisor   (s_eff[zso_pkg::SIZE_W-1:0]),
      .remainder (row_rem),
      .status    (row_st)
   );

   // ---------------------------------------------------------------------
   // Output register and skid entry
   // ---------------------------------------------------------------------
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take) out_valid_in = 1'b0;
      if (skid_valid_ff && out_take) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_new;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_ff.red;
   assign rsp_green_out = out_ff.green;
   assign rsp_blue_out  = out_ff.blue;
   assign rsp_alpha_out = out_ff.alpha;
   assign rsp_frame_end = out_ff.frame_end;

`ifndef NO_ASSERTIONS
   // Skid entry only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // No pixel enters while the phases are being reloaded
   a_no_accept_reload: assert property (@(posedge clock) disable iff (reset)
      (state_ff != zso_pkg::ST_RUN) |-> !accept)
      else $error("pixel accepted during phase reload");

   // Stripe phases stay below the stripe size and do not exceed the counters
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == zso_pkg::ST_RUN) |->
         ((XW'(pphase_ff) < s_eff) && (pphase_ff <= col_ff) &&
          (XW'(lphase_ff) < s_eff) && (lphase_ff <= row_ff)))
      else $error("stripe phase out of range");

   // Both dividers finish together
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      col_st.done == row_st.done)
      else $error("divider completion mismatch");
`endif

endmodule

/* rtl/zso_div.sv */
// ============================================================================
// zso_div - iterative counter divider
// Restoring division, one quotient bit per cycle. Gives the remainder and
// the quotient parity used to reload a stripe phase after a size change.
// ============================================================================
module zso_div #(
   parameter int CW = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [CW-1:0]                dividend,
   input  logic [zso_pkg::SIZE_W-1:0]   divisor,
   output logic [CW-1:0]                remainder,
   output zso_pkg::div_status_type      status
);

   localparam int MW  = (CW > zso_pkg::SIZE_W) ? CW : zso_pkg::SIZE_W;
   localparam int CNW = $clog2(CW + 1);

   logic [CW-1:0]     dvd_ff,  dvd_in;
   logic [MW-1:0]     rem_ff,  rem_in;
   logic [MW-1:0]     dsr_ff,  dsr_in;
   logic [CNW-1:0]    cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              qbit_ff, qbit_in;
   logic [MW:0]       trial;
   logic              fits;

   // One restoring step
   assign trial = {rem_ff, dvd_ff[CW-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      qbit_in = qbit_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = MW'(divisor);
         cnt_in  = CNW'(CW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[CW-2:0], 1'b0};
         rem_in  = fits ? MW'(trial - {1'b0, dsr_ff}) : MW'(trial);
         qbit_in = fits;
         cnt_in  = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      qbit_ff <= qbit_in;
   end

   assign remainder       = CW'(rem_ff);
   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.quot_lsb = qbit_ff;

endmodule
